// File: design/sme_pkg.sv
`default_nettype none

package sme_pkg;

  // default sizes of the operand stack and the data buffer
  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned DATA_BYTES_DEF  = 64;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  // instruction opcodes
  localparam logic [7:0] OPC_PUSH = 8'h01;
  localparam logic [7:0] OPC_ADD  = 8'h03;
  localparam logic [7:0] OPC_SUB  = 8'h04;
  localparam logic [7:0] OPC_XOR  = 8'h05;
  localparam logic [7:0] OPC_MUL  = 8'h06;
  localparam logic [7:0] OPC_AND  = 8'h07;
  localparam logic [7:0] OPC_OR   = 8'h08;
  localparam logic [7:0] OPC_ROL  = 8'h09;
  localparam logic [7:0] OPC_SHR  = 8'h0A;
  localparam logic [7:0] OPC_END  = 8'hFF;

  // result status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_DONE   = 2'd1;
  localparam logic [1:0] STS_BADOP  = 2'd2;
  localparam logic [1:0] STS_HALTED = 2'd3;

  // input beat
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] opcode;
    logic [7:0] operand;
    logic [7:0] data_byte;
  } sme_in_t;

  // output beat
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
    logic [8:0]  depth;
  } sme_out_t;

  // item class after decode
  typedef enum logic [3:0] {
    K_WRITE,
    K_START,
    K_NOP,
    K_PUSH,
    K_ALU2,
    K_ROL,
    K_SHR,
    K_END,
    K_BAD
  } kind_e;

  // two-operand operations
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_XOR,
    ALU_MUL,
    ALU_AND,
    ALU_OR
  } alu_e;

  // decoded item held in the queue
  typedef struct packed {
    kind_e      kind;
    alu_e       alu;
    logic [7:0] operand;
    logic [7:0] data_byte;
  } sme_op_t;

  // queue head seen by the execution side
  typedef struct packed {
    logic    valid;
    sme_op_t op;
  } sme_qhead_t;

endpackage

`default_nettype wire

// File: design/sme_front.sv
`default_nettype none

module sme_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sme_pkg::sme_in_t    in_data_i,
  input  logic                pop_i,
  output sme_pkg::sme_qhead_t head_o
);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  sme_pkg::sme_op_t op_dec;
  sme_pkg::sme_op_t mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push;

  // classify the incoming beat
  always_comb begin
    op_dec.kind      = sme_pkg::K_NOP;
    op_dec.alu       = sme_pkg::ALU_ADD;
    op_dec.operand   = in_data_i.operand;
    op_dec.data_byte = in_data_i.data_byte;
    unique case (in_data_i.command)
      sme_pkg::CMD_WRITE: op_dec.kind = sme_pkg::K_WRITE;
      sme_pkg::CMD_START: op_dec.kind = sme_pkg::K_START;
      sme_pkg::CMD_NOP:   op_dec.kind = sme_pkg::K_NOP;
      sme_pkg::CMD_EXEC: begin
        unique case (in_data_i.opcode)
          sme_pkg::OPC_PUSH: op_dec.kind = sme_pkg::K_PUSH;
          sme_pkg::OPC_ADD: begin
            op_dec.kind = sme_pkg::K_ALU2;
            op_dec.alu  = sme_pkg::ALU_ADD;
          end
          sme_pkg::OPC_SUB: begin
            op_dec.kind = sme_pkg::K_ALU2;
            op_dec.alu  = sme_pkg::ALU_SUB;
          end
          sme_pkg::OPC_XOR: begin
            op_dec.kind = sme_pkg::K_ALU2;
            op_dec.alu  = sme_pkg::ALU_XOR;
          end
          sme_pkg::OPC_MUL: begin
            op_dec.kind = sme_pkg::K_ALU2;
            op_dec.alu  = sme_pkg::ALU_MUL;
          end
          sme_pkg::OPC_AND: begin
            op_dec.kind = sme_pkg::K_ALU2;
            op_dec.alu  = sme_pkg::ALU_AND;
          end
          sme_pkg::OPC_OR: begin
            op_dec.kind = sme_pkg::K_ALU2;
            op_dec.alu  = sme_pkg::ALU_OR;
          end
          sme_pkg::OPC_ROL: op_dec.kind = sme_pkg::K_ROL;
          sme_pkg::OPC_SHR: op_dec.kind = sme_pkg::K_SHR;
          sme_pkg::OPC_END: op_dec.kind = sme_pkg::K_END;
          default:          op_dec.kind = sme_pkg::K_BAD;
        endcase
      end
    endcase
  end

  // queue handshake
  assign in_stall_o = (cnt_q == CntW'(QueueDepth));
  assign push       = in_valid_i && !in_stall_o;

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= op_dec;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = mem_q[rd_q];

endmodule

`default_nettype wire

// File: design/sme_back.sv
`default_nettype none

module sme_back #(
  parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DATA_BYTES  = sme_pkg::DATA_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sme_pkg::sme_qhead_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sme_pkg::sme_out_t   out_data_o
);

  localparam int unsigned CntW      = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW     = $clog2(STACK_DEPTH);
  localparam int unsigned WordBytes = 8;
  localparam int unsigned Rows      = (DATA_BYTES + WordBytes - 1) / WordBytes;
  localparam int unsigned RowW      = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned ByteW     = $clog2(DATA_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_MUL  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              halted_q, halted_d;
  sme_pkg::sme_op_t  it_q;
  logic [63:0]       stack_mem [STACK_DEPTH];
  logic [63:0]       rda_q, rdb_q;
  logic [DATA_BYTES-1:0] dvalid_q;
  logic [7:0]        bank_rd_q [WordBytes];
  logic              bank_ok_q [WordBytes];
  logic [RowW-1:0]   bank_row [WordBytes];
  logic              bank_ok [WordBytes];
  logic [63:0]       mul_lo_q;
  logic [31:0]       mul_x_q, mul_y_q;
  logic              out_valid_q;
  sme_pkg::sme_out_t out_q, res;

  logic              take, finish, mul_go, out_free, dwe;
  logic              stk_we;
  logic [AddrW-1:0]  stk_wa, rd_a_addr, rd_b_addr;
  logic [63:0]       stk_wd;
  logic [CntW-1:0]   cnt_m1, cnt_m2, cnt_pop1, cnt_pop2;
  logic [63:0]       opa, opb, push_word, alu_res, rol_res, shr_res, mul_sum;
  logic [127:0]      rol_wide;

  // take the queue head only when the previous item is written back
  assign take  = (state_q == S_IDLE) && head_i.valid;
  assign pop_o = take;

  // stack read addresses: top and next below top
  assign cnt_m1    = cnt_q - CntW'(1);
  assign cnt_m2    = cnt_q - CntW'(2);
  assign rd_a_addr = cnt_m1[AddrW-1:0];
  assign rd_b_addr = cnt_m2[AddrW-1:0];

  // operand stack memory, two registered reads and one write
  always_ff @(posedge clk_i) begin
    if (take) begin
      rda_q <= stack_mem[rd_a_addr];
      rdb_q <= stack_mem[rd_b_addr];
    end
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
  end

  // bank addresses for an eight byte load starting at the operand
  always_comb begin
    logic [2:0] off;
    logic [8:0] addr;
    for (int j = 0; j < WordBytes; j++) begin
      off         = 3'(j) - head_i.op.operand[2:0];
      addr        = {1'b0, head_i.op.operand} + {6'b0, off};
      bank_row[j] = addr[RowW+2:3];
      bank_ok[j]  = (addr < 9'(DATA_BYTES)) && dvalid_q[addr[ByteW-1:0]];
    end
  end

  // data buffer: one byte-wide bank per byte lane
  for (genvar j = 0; j < WordBytes; j++) begin : g_bank
    logic [7:0] mem [Rows];

    always_ff @(posedge clk_i) begin
      if (dwe && (it_q.operand[2:0] == 3'(j))) begin
        mem[it_q.operand[RowW+2:3]] <= it_q.data_byte;
      end
      if (take) begin
        bank_rd_q[j] <= mem[bank_row[j]];
        bank_ok_q[j] <= bank_ok[j];
      end
    end
  end

  // written-byte flags, unwritten bytes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvalid_q <= '0;
    end else if (dwe) begin
      dvalid_q[it_q.operand[ByteW-1:0]] <= 1'b1;
    end
  end

  // item register
  always_ff @(posedge clk_i) begin
    if (take) begin
      it_q <= head_i.op;
    end
  end

  // popped operands, zero from an empty stack
  assign opa      = (cnt_q != '0) ? rda_q : '0;
  assign opb      = (cnt_q > CntW'(1)) ? rdb_q : '0;
  assign cnt_pop1 = (cnt_q != '0) ? cnt_m1 : '0;
  assign cnt_pop2 = (cnt_q > CntW'(1)) ? cnt_m2 : '0;

  // gather load bytes back into word order
  always_comb begin
    logic [2:0] lane;
    for (int k = 0; k < WordBytes; k++) begin
      lane = it_q.operand[2:0] + 3'(k);
      push_word[8*k +: 8] = bank_ok_q[lane] ? bank_rd_q[lane] : 8'h00;
    end
  end

  // shifts
  assign rol_wide = {opa, opa} << it_q.operand[5:0];
  assign rol_res  = rol_wide[127:64];
  assign shr_res  = (it_q.operand[7:6] != 2'b00) ? '0 : (opa >> it_q.operand[5:0]);

  // low 64 bits of the product from three 32-bit partial products
  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      mul_lo_q <= opa[31:0] * opb[31:0];
      mul_x_q  <= opa[31:0] * opb[63:32];
      mul_y_q  <= opa[63:32] * opb[31:0];
    end
  end
  assign mul_sum = mul_lo_q + {mul_x_q + mul_y_q, 32'h0};

  // two-operand result
  always_comb begin
    case (it_q.alu)
      sme_pkg::ALU_ADD: alu_res = opa + opb;
      sme_pkg::ALU_SUB: alu_res = opa - opb;
      sme_pkg::ALU_XOR: alu_res = opa ^ opb;
      sme_pkg::ALU_MUL: alu_res = mul_sum;
      sme_pkg::ALU_AND: alu_res = opa & opb;
      sme_pkg::ALU_OR:  alu_res = opa | opb;
      default:          alu_res = '0;
    endcase
  end

  // sequencer
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    finish  = 1'b0;
    mul_go  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (it_q.kind == sme_pkg::K_ALU2 && it_q.alu == sme_pkg::ALU_MUL && !halted_q) begin
          mul_go  = 1'b1;
          state_d = S_MUL;
        end else if (out_free) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // write-back of one item
  always_comb begin
    cnt_d      = cnt_q;
    halted_d   = halted_q;
    stk_we     = 1'b0;
    stk_wa     = '0;
    stk_wd     = '0;
    dwe        = 1'b0;
    res.status = sme_pkg::STS_OK;
    res.value  = '0;
    if (finish) begin
      case (it_q.kind) inside
        sme_pkg::K_WRITE: dwe = ({1'b0, it_q.operand} < 9'(DATA_BYTES));
        sme_pkg::K_START: begin
          cnt_d    = '0;
          halted_d = 1'b0;
        end
        sme_pkg::K_NOP: ;
        default: begin
          if (halted_q) begin
            res.status = sme_pkg::STS_HALTED;
          end else begin
            case (it_q.kind) inside
              sme_pkg::K_PUSH: begin
                if (cnt_q < CntW'(STACK_DEPTH)) begin
                  stk_we = 1'b1;
                  stk_wa = cnt_q[AddrW-1:0];
                  stk_wd = push_word;
                  cnt_d  = cnt_q + CntW'(1);
                end
              end
              sme_pkg::K_ALU2: begin
                stk_we = 1'b1;
                stk_wa = cnt_pop2[AddrW-1:0];
                stk_wd = alu_res;
                cnt_d  = cnt_pop2 + CntW'(1);
              end
              sme_pkg::K_ROL, sme_pkg::K_SHR: begin
                stk_we = 1'b1;
                stk_wa = cnt_pop1[AddrW-1:0];
                stk_wd = (it_q.kind == sme_pkg::K_ROL) ? rol_res : shr_res;
                cnt_d  = cnt_pop1 + CntW'(1);
              end
              sme_pkg::K_END: begin
                cnt_d      = cnt_pop1;
                halted_d   = 1'b1;
                res.status = sme_pkg::STS_DONE;
                res.value  = opa;
              end
              default: begin
                halted_d   = 1'b1;
                res.status = sme_pkg::STS_BADOP;
              end
            endcase
          end
        end
      endcase
    end
    res.depth = 9'(cnt_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: design/stack_machine_evaluator.sv
`default_nettype none

// 64-bit stack machine. Each input beat is one command: a data byte write into the
// load buffer, an instruction, a start that empties the stack and clears the halt,
// or a no-op. Every beat gives exactly one output beat with status, popped value
// and stack depth. Beats enter a two-entry queue after decode, so until it fills
// the input keeps flowing while the execution side works or the output is stalled.
// No new item is taken before the last is written back: both top stack entries are
// read with registered data when an item is taken, and the result is written back
// before the next item may read the stack. Unless halted, MUL adds the S_MUL state
// for its registered 32-bit partial products. No clearing pass runs after reset.
module stack_machine_evaluator #(
  parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DATA_BYTES  = sme_pkg::DATA_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sme_pkg::sme_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sme_pkg::sme_out_t out_data_o
);

  sme_pkg::sme_qhead_t q_head;
  logic                q_pop;

  // decode and queue
  sme_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .pop_i      (q_pop),
    .head_o     (q_head)
  );

  // stack execution
  sme_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_BYTES  (DATA_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // the execution side only takes an item that the queue holds
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

  // items are spaced so write-back lands before the next stack read
  a_pop_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop)
    else $error("back-to-back queue pops");

  // value is only carried by a finishing beat
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != sme_pkg::STS_DONE)) |-> (out_data_o.value == '0))
    else $error("nonzero value without finish status");
`endif

endmodule

`default_nettype wire
